// File: rtl/core/sfa_pkg.sv
// Package: types, constants and codes for the subdirectory fill allocator.
package sfa_pkg;

  localparam int NUM_PATHS        = 8;
  localparam int ENTRIES_PER_PATH = 64;
  localparam int PATH_W  = 3;
  localparam int SLOT_W  = $clog2(ENTRIES_PER_PATH);
  localparam int TABLE_SIZE = NUM_PATHS * ENTRIES_PER_PATH;
  localparam int ADDR_W  = $clog2(TABLE_SIZE);
  localparam int SD_W    = 31;
  localparam int CNT_W   = 32;
  localparam int TRUNK_W = 63;
  localparam int CFG_W   = 63;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DEL    = 2'd1;
  localparam logic [1:0] OP_GEN    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PATH = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_FILES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SUBDIR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_TRUNK = 2'd3;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [PATH_W-1:0] store_path;
    logic [SD_W-1:0] subdir_number;
  } sfa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SD_W-1:0]    chosen_subdir;
    logic [TRUNK_W-1:0] trunk_number;
  } sfa_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LAST, S_APPLY, S_DONE
  } sfa_state_t;

endpackage

// File: rtl/core/subdir_fill_allocator.sv
// Top level: per-path subdirectory table with a sequential slot scan.
// The scan reads every slot of the item's path in S_SCAN, then passes S_LAST and S_APPLY before the result is valid.
// A new item is taken only in S_IDLE once the previous result has been accepted;
// the single-port table read walks one slot per cycle.
// Disabled-path and unused-opcode items skip the scan and go straight to S_DONE.
// Reset (rst_n, synchronous): valid/free bits clear, registers and counters to defaults.
module subdir_fill_allocator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sfa_pkg::sfa_in_t      in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sfa_pkg::sfa_out_t     out_data,
  input  logic                  cfg_we,
  input  logic [sfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfa_pkg::CFG_W-1:0]     cfg_wdata
);
  import sfa_pkg::*;

  logic [SD_W-1:0] subdir_mem [TABLE_SIZE];
  logic [CNT_W-1:0] count_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid_r, free_r;

  logic [15:0] max_files_r;
  logic [7:0]  path_mask_r;
  logic [SD_W-1:0] subdir_ctr_r;
  logic [TRUNK_W-1:0] trunk_ctr_r;

  sfa_state_t state_r, state_nxt;
  sfa_in_t    cmd_r;
  logic [SLOT_W:0] idx_r;        // issued read index
  logic [SLOT_W-1:0] rd_slot_r;  // slot of registered read data
  logic rd_vld_r;
  logic [SD_W-1:0]  rd_sd_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic hit_r, empty_found_r, free_found_r;
  logic [SLOT_W-1:0] hit_slot_r, empty_slot_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic [SD_W-1:0] best_sd_r;
  sfa_out_t out_r;
  logic out_valid_r;

  logic path_ok;
  assign path_ok = path_mask_r[in_data.store_path];

  function automatic logic [ADDR_W-1:0] addr_of(logic [PATH_W-1:0] p, logic [SLOT_W-1:0] s);
    return {p, s};
  endfunction

  logic [ADDR_W-1:0] rd_addr, rd_full;
  assign rd_addr = addr_of(cmd_r.store_path, idx_r[SLOT_W-1:0]);
  assign rd_full = addr_of(cmd_r.store_path, rd_slot_r);

  logic rd_v, rd_f;
  assign rd_v = valid_r[rd_full];
  assign rd_f = free_r[rd_full];

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // table read port
  always_ff @(posedge clk) begin
    rd_sd_r  <= subdir_mem[rd_addr];
    rd_cnt_r <= count_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid && in_ready) begin
        if (in_data.opcode == OP_UNUSED || !path_ok) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_SCAN:  if (idx_r == (SLOT_W+1)'(ENTRIES_PER_PATH)) state_nxt = S_LAST;
      S_LAST:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  logic [CNT_W-1:0] inc_cnt, dec_cnt;
  assign inc_cnt = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
  assign dec_cnt = (hit_cnt_r == '0) ? hit_cnt_r : hit_cnt_r - 1'b1;
  logic [ADDR_W-1:0] hit_addr, empty_addr;
  assign hit_addr   = addr_of(cmd_r.store_path, hit_slot_r);
  assign empty_addr = addr_of(cmd_r.store_path, empty_slot_r);

  always_ff @(posedge clk) begin
    if (state_r == S_APPLY && cmd_r.opcode != OP_GEN) begin
      if (hit_r) begin
        count_mem[hit_addr] <= (cmd_r.opcode == OP_ADD) ? inc_cnt : dec_cnt;
      end else if (cmd_r.opcode == OP_ADD && empty_found_r) begin
        count_mem[empty_addr]  <= CNT_W'(1);
        subdir_mem[empty_addr] <= cmd_r.subdir_number;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      free_r <= '0;
      max_files_r <= 16'd100;
      path_mask_r <= 8'hFF;
      subdir_ctr_r <= '0;
      trunk_ctr_r <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_FILES:    max_files_r <= cfg_wdata[15:0];
          REG_PATH_MASK:    path_mask_r <= cfg_wdata[7:0];
          REG_START_SUBDIR: subdir_ctr_r <= cfg_wdata[SD_W-1:0];
          REG_START_TRUNK:  trunk_ctr_r <= cfg_wdata[TRUNK_W-1:0];
          default: ;
        endcase
      end
      rd_vld_r <= (state_r == S_SCAN) && (idx_r != (SLOT_W+1)'(ENTRIES_PER_PATH));
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          cmd_r <= in_data;
          idx_r <= '0;
          hit_r <= 1'b0;
          empty_found_r <= 1'b0;
          free_found_r <= 1'b0;
          out_r <= '0;
          if (in_data.opcode != OP_UNUSED && !path_ok) out_r.status <= ST_NO_PATH;
        end
        S_SCAN: if (idx_r != (SLOT_W+1)'(ENTRIES_PER_PATH)) begin
          idx_r <= idx_r + 1'b1;
          rd_slot_r <= idx_r[SLOT_W-1:0];
        end
        S_APPLY: begin
          case (cmd_r.opcode)
            OP_ADD: begin
              if (hit_r) begin
                if (inc_cnt >= CNT_W'(max_files_r)) free_r[hit_addr] <= 1'b0;
              end else if (empty_found_r) begin
                valid_r[empty_addr] <= 1'b1;
                free_r[empty_addr]  <= (16'd1 < max_files_r);
              end else out_r.status <= ST_FULL;
            end
            OP_DEL: if (hit_r && hit_cnt_r >= CNT_W'(max_files_r))
              free_r[hit_addr] <= 1'b1;
            OP_GEN: begin
              if (free_found_r) out_r.chosen_subdir <= best_sd_r;
              else begin
                subdir_ctr_r <= subdir_ctr_r + 1'b1;
                out_r.chosen_subdir <= subdir_ctr_r + 1'b1;
              end
              trunk_ctr_r <= trunk_ctr_r + 1'b1;
              out_r.trunk_number <= trunk_ctr_r + 1'b1;
            end
            default: ;
          endcase
          out_valid_r <= 1'b1;
        end
        S_DONE: out_valid_r <= 1'b1;
        default: ;
      endcase
      // compare unit: one slot per cycle
      if (rd_vld_r) begin
        if (rd_v && rd_sd_r == cmd_r.subdir_number && !hit_r) begin
          hit_r <= 1'b1;
          hit_slot_r <= rd_slot_r;
          hit_cnt_r <= rd_cnt_r;
        end
        if (!rd_v && !empty_found_r) begin
          empty_found_r <= 1'b1;
          empty_slot_r <= rd_slot_r;
        end
        if (rd_v && rd_f && (!free_found_r || rd_sd_r < best_sd_r)) begin
          free_found_r <= 1'b1;
          best_sd_r <= rd_sd_r;
        end
      end
    end
  end

endmodule

// File: rtl/core/sfa_checker.sv
// Checker: port-level properties of the allocator, bound to the top level.
module sfa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sfa_pkg::sfa_out_t out_data
);
  import sfa_pkg::*;

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after transfer");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_FULL) else $error("bad status");
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.trunk_number == '0)
    else $error("trunk on failed item");

endmodule

bind subdir_fill_allocator sfa_checker u_sfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// File: verif/subdir_fill_allocator_chk.sv
// Checker: predicts allocator results from observed transfers and compares them.
`timescale 1ns / 1ps
module subdir_fill_allocator_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  sfa_pkg::sfa_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  sfa_pkg::sfa_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [sfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfa_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen
);
  import sfa_pkg::*;

  logic [15:0]        fill_limit;
  logic [7:0]         path_mask;
  logic [SD_W-1:0]    sd_ctr;
  logic [TRUNK_W-1:0] trunk_ctr;
  logic [SD_W-1:0]    slot_sd   [TABLE_SIZE];
  logic [CNT_W-1:0]   slot_cnt  [TABLE_SIZE];
  logic               slot_used [TABLE_SIZE];
  logic               slot_free [TABLE_SIZE];
  sfa_out_t           expected_q[$];

  function automatic sfa_out_t allocate(sfa_in_t it);
    sfa_out_t r;
    int base, hit, i;
    logic found;
    r = '0;
    base = int'(it.store_path) * ENTRIES_PER_PATH;
    hit = -1;
    found = 1'b0;
    if (it.opcode == OP_UNUSED) return r;
    if (!path_mask[it.store_path]) begin
      r.status = ST_NO_PATH;
      return r;
    end
    for (i = 0; i < ENTRIES_PER_PATH; i++)
      if (hit < 0 && slot_used[base+i] && slot_sd[base+i] == it.subdir_number) hit = base + i;
    case (it.opcode)
      OP_ADD: begin
        if (hit >= 0) begin
          if (slot_cnt[hit] != '1) slot_cnt[hit]++;
          if (slot_cnt[hit] >= fill_limit) slot_free[hit] = 1'b0;
        end else begin
          for (i = 0; i < ENTRIES_PER_PATH; i++)
            if (hit < 0 && !slot_used[base+i]) hit = base + i;
          if (hit < 0) r.status = ST_FULL;
          else begin
            slot_used[hit] = 1'b1;
            slot_sd[hit]   = it.subdir_number;
            slot_cnt[hit]  = CNT_W'(1);
            slot_free[hit] = fill_limit > 16'd1;
          end
        end
      end
      OP_DEL: begin
        if (hit >= 0) begin
          if (slot_cnt[hit] >= fill_limit) slot_free[hit] = 1'b1;
          if (slot_cnt[hit] != '0) slot_cnt[hit]--;
        end
      end
      default: begin
        for (i = 0; i < ENTRIES_PER_PATH; i++)
          if (slot_used[base+i] && slot_free[base+i] &&
              (!found || slot_sd[base+i] < r.chosen_subdir)) begin
            r.chosen_subdir = slot_sd[base+i];
            found = 1'b1;
          end
        if (!found) begin
          sd_ctr = sd_ctr + 1'b1;
          r.chosen_subdir = sd_ctr;
        end
        trunk_ctr = trunk_ctr + 1'b1;
        r.trunk_number = trunk_ctr;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    sfa_out_t want;
    if (!rst_n) begin
      fill_limit = 16'd100;
      path_mask  = 8'hFF;
      sd_ctr     = '0;
      trunk_ctr  = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_used[i] = 1'b0;
        slot_free[i] = 1'b0;
      end
      expected_q.delete();
      fail_count   <= 0;
      results_seen <= 0;
      pending      <= 0;
    end else begin
      if (cfg_we)
        case (cfg_index)
          REG_MAX_FILES:    fill_limit = cfg_wdata[15:0];
          REG_PATH_MASK:    path_mask  = cfg_wdata[7:0];
          REG_START_SUBDIR: sd_ctr     = cfg_wdata[SD_W-1:0];
          default:          trunk_ctr  = cfg_wdata[TRUNK_W-1:0];
        endcase
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.status !== out_data.status || want.chosen_subdir !== out_data.chosen_subdir ||
              want.trunk_number !== out_data.trunk_number) begin
            if (fail_count < 10)
              $display("mismatch: exp st=%0d sd=%0d tr=%0d got st=%0d sd=%0d tr=%0d",
                       want.status, want.chosen_subdir, want.trunk_number,
                       out_data.status, out_data.chosen_subdir, out_data.trunk_number);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_q.push_back(allocate(in_data));
      pending <= expected_q.size();
    end
  end
endmodule

// File: verif/subdir_fill_allocator_tb.sv
// Testbench top: clock, reset, stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module subdir_fill_allocator_tb;
  import sfa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  sfa_in_t  in_data = '0;
  sfa_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_FILES;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int fail_count, pending, results_seen;
  int send_idle = 0, recv_stall = 0;
  logic hold_req = 1'b0;
  logic hold_used = 1'b0;
  int hold_off = 0;
  int items_sent = 0;
  logic [SD_W-1:0] sd_pool[8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  subdir_fill_allocator uut (.*);
  subdir_fill_allocator_chk checker_i (.*);

  // receiver: random stall plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_off <= 400;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic transfer(logic [1:0] op, logic [PATH_W-1:0] p, logic [SD_W-1:0] sd);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, store_path: p, subdir_number: sd};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic random_item();
    logic [1:0] op;
    logic [PATH_W-1:0] p;
    logic [SD_W-1:0] sd;
    int r;
    r = int'($urandom_range(99));
    op = (r < 45) ? OP_ADD : (r < 75) ? OP_DEL : (r < 97) ? OP_GEN : OP_UNUSED;
    p = ($urandom_range(3) == 0) ? PATH_W'($urandom) : PATH_W'($urandom_range(1));
    sd = ($urandom_range(9) == 0) ? SD_W'($urandom) : sd_pool[$urandom_range(7)];
    transfer(op, p, sd);
  endtask

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) sd_pool[i] = SD_W'($urandom);
    sd_pool[0] = '0;
    sd_pool[1] = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: limits, every opcode, disabled path, unknown delete, wrap
    cfg_write(REG_MAX_FILES, CFG_W'(2));
    transfer(OP_GEN, 3'd0, '0);
    transfer(OP_ADD, 3'd0, '1);
    transfer(OP_ADD, 3'd0, SD_W'(5));
    transfer(OP_GEN, 3'd0, '0);
    transfer(OP_ADD, 3'd0, SD_W'(5));
    transfer(OP_GEN, 3'd0, '0);
    transfer(OP_DEL, 3'd0, SD_W'(5));
    transfer(OP_DEL, 3'd0, SD_W'(77));
    transfer(OP_UNUSED, 3'd7, '1);
    transfer(OP_DEL, 3'd0, '1);
    transfer(OP_DEL, 3'd0, '1);
    transfer(OP_DEL, 3'd0, '1);
    transfer(OP_GEN, 3'd0, '0);
    drain();
    cfg_write(REG_PATH_MASK, CFG_W'(8'h5A));
    cfg_write(REG_START_SUBDIR, CFG_W'(31'h7FFF_FFFF));
    cfg_write(REG_START_TRUNK, 63'h7FFF_FFFF_FFFF_FFFF);
    cfg_write(REG_MAX_FILES, CFG_W'(1));
    transfer(OP_GEN, 3'd3, '0);
    transfer(OP_GEN, 3'd0, '0);
    transfer(OP_ADD, 3'd2, SD_W'(9));
    transfer(OP_DEL, 3'd5, SD_W'(9));
    transfer(OP_ADD, 3'd1, '0);
    transfer(OP_GEN, 3'd1, '0);
    // fill one table to overflow, with the receiver held off so input stalls
    hold_req <= 1'b1;
    for (int i = 0; i < 66; i++) transfer(OP_ADD, 3'd3, SD_W'(1000 + i));
    drain();
    cfg_write(REG_PATH_MASK, CFG_W'(8'hFF));
    cfg_write(REG_MAX_FILES, CFG_W'(16'hFFFF));
    cfg_write(REG_START_SUBDIR, '0);
    cfg_write(REG_START_TRUNK, '0);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1) ? 60 : (ph == 3) ? 12 : 0;
      recv_stall = (ph == 2) ? 60 : (ph == 3) ? 12 : 0;
      cfg_write(REG_MAX_FILES, CFG_W'($urandom_range(1, 6)));
      if (ph == 2) cfg_write(REG_PATH_MASK, CFG_W'(8'($urandom)));
      for (int i = 0; i < 360; i++) random_item();
      drain();
      if (ph == 2) cfg_write(REG_PATH_MASK, CFG_W'(8'hFF));
    end
    send_idle = 0;
    recv_stall = 0;
    $display("Sent %0d items over directed, table-full and four random phases; %0d results checked.",
             items_sent, results_seen);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
